// ===== hdl/pct_pkg.sv =====
// Shared types and constants for the pairwise coverage tracker.
`timescale 1ns / 1ps

package pct_pkg;

    localparam int KIND_W = 2;
    localparam int ASG_W  = 64;
    localparam int LIT_W  = 8;
    localparam int NF_W   = 7;
    localparam int FEAT_W = 6;
    localparam int CNT_W  = 13;

    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RSVD  = 2'd3;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ASG_W-1:0]  bits;     // assignment, add items
        logic [NF_W-1:0]   n;        // tracked feature count, clamped
        logic [FEAT_W-1:0] lo;       // lower feature index of a query
        logic [FEAT_W-1:0] hi;       // upper feature index of a query
        logic [1:0]        pidx;     // {polarity lo, polarity hi}
        logic              invalid;  // query literals unusable
    } t_cmd;

endpackage

// ===== hdl/pct_if.sv =====
// Item and result channel interfaces.
`timescale 1ns / 1ps

interface pct_item_if;
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [63:0]       assignment_bits;
    logic signed [7:0] lit_a;
    logic signed [7:0] lit_b;

    modport source (output valid, kind, assignment_bits, lit_a, lit_b, input ready);
    modport sink   (input valid, kind, assignment_bits, lit_a, lit_b, output ready);
endinterface

interface pct_result_if;
    logic        valid;
    logic        ready;
    logic [12:0] covered_count;
    logic        pair_covered;
    logic        pair_invalid;

    modport source (output valid, covered_count, pair_covered, pair_invalid, input ready);
    modport sink   (input valid, covered_count, pair_covered, pair_invalid, output ready);
endinterface

// ===== hdl/pct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pct_ram #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hdl/pct_front.sv =====
// Front end: accepts items, decodes literals and checks query validity.
`timescale 1ns / 1ps

module pct_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pct_item_if.sink            i_item,
    input  logic [6:0]          i_num_feat,
    output logic                o_cmd_valid,
    input  logic                i_cmd_ready,
    output pct_pkg::t_cmd       o_cmd
);

    logic          r_valid;
    pct_pkg::t_cmd r_cmd;
    pct_pkg::t_cmd n_cmd;
    logic [7:0]    va, vb, vlo, vhi;
    logic          pa, pb, plo, phi;

    assign i_item.ready = !r_valid || i_cmd_ready;
    assign o_cmd_valid  = r_valid;
    assign o_cmd        = r_cmd;

    always_comb begin
        // magnitude and polarity of each signed literal
        va = i_item.lit_a[7] ? (8'd0 - i_item.lit_a) : i_item.lit_a;
        vb = i_item.lit_b[7] ? (8'd0 - i_item.lit_b) : i_item.lit_b;
        pa = !i_item.lit_a[7];
        pb = !i_item.lit_b[7];
        if (va < vb) begin
            vlo = va; plo = pa; vhi = vb; phi = pb;
        end else begin
            vlo = vb; plo = pb; vhi = va; phi = pa;
        end
        n_cmd.kind    = i_item.kind;
        n_cmd.bits    = i_item.assignment_bits;
        n_cmd.n       = i_num_feat;
        n_cmd.lo      = pct_pkg::FEAT_W'(vlo - 8'd1);
        n_cmd.hi      = pct_pkg::FEAT_W'(vhi - 8'd1);
        n_cmd.pidx    = {plo, phi};
        n_cmd.invalid = (va == 8'd0) || (vb == 8'd0) || (va > {1'b0, i_num_feat})
                     || (vb > {1'b0, i_num_feat}) || (va == vb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_item.valid && i_item.ready) begin
            r_valid <= 1'b1;
        end else if (i_cmd_ready) begin
            r_valid <= 1'b0;
        end
        if (i_item.valid && i_item.ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== hdl/pct_cmd_fifo.sv =====
// Short command queue between front end and back end.
`timescale 1ns / 1ps

module pct_cmd_fifo #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_valid,
    output logic          o_wr_ready,
    input  pct_pkg::t_cmd i_wr_cmd,
    output logic          o_rd_valid,
    input  logic          i_rd_ready,
    output pct_pkg::t_cmd o_rd_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pct_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;
    logic          push, pop;

    assign o_wr_ready = (r_cnt != CW'(DEPTH));
    assign o_rd_valid = (r_cnt != '0);
    assign o_rd_cmd   = r_mem[r_rp];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
        if (push) begin
            r_mem[r_wp] <= i_wr_cmd;
        end
    end

endmodule

// ===== hdl/pct_back.sv =====
// Back end: row-wise mark store update, queries, clears and result register.
`timescale 1ns / 1ps

module pct_back #(
    parameter int MAX_FEATURES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  pct_pkg::t_cmd i_cmd,
    pct_result_if.source  o_result
);

    localparam int AW   = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int RW   = 4 * MAX_FEATURES;
    localparam int NG   = (MAX_FEATURES + 7) / 8;
    localparam int PADW = NG * 8;
    localparam int CW   = pct_pkg::CNT_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ADD  = 3'd1;
    localparam logic [2:0] ST_QRD  = 3'd2;
    localparam logic [2:0] ST_QWT  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]              r_state;
    pct_pkg::t_cmd           r_cmd;
    logic [pct_pkg::NF_W-1:0] r_row;
    logic [MAX_FEATURES-1:0] r_rowv;
    logic [CW-1:0]           r_total;
    logic                    r_s1_v, r_s2_v, r_s3_v;
    logic [AW-1:0]           r_s1_row;
    logic [PADW-1:0]         r_new;
    logic [3:0]              r_grp [NG];
    logic                    r_cov, r_inv;
    logic                    r_ov;
    logic [CW-1:0]           r_oc;
    logic                    r_ocov, r_oinv;

    logic [AW-1:0]   raddr;
    logic [RW-1:0]   rdata, old_row, wrow;
    logic [PADW-1:0] newb;
    logic [3:0]      gsum [NG];
    logic [6:0]      tsum;
    logic            vi, active, issue, take, out_free;
    logic [1:0]      sel;

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign take        = i_cmd_valid && o_cmd_ready;
    assign issue       = (r_state == ST_ADD) && (r_row < r_cmd.n);
    assign raddr       = (r_state == ST_ADD) ? r_row[AW-1:0] : r_cmd.lo[AW-1:0];
    assign out_free    = !r_ov || o_result.ready;

    pct_ram #(.WIDTH(RW), .DEPTH(MAX_FEATURES)) u_marks (
        .i_clk   (i_clk),
        .i_we    (r_s1_v),
        .i_waddr (r_s1_row),
        .i_wdata (wrow),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // merge one row: pairs (row, j) with row < j < n get the seen combination
    always_comb begin
        old_row = r_rowv[r_s1_row] ? rdata : '0;
        vi      = r_cmd.bits[r_s1_row];
        wrow    = old_row;
        newb    = '0;
        for (int j = 0; j < MAX_FEATURES; j++) begin
            sel    = {vi, r_cmd.bits[j]};
            active = (j > int'(r_s1_row)) && (j < int'(r_cmd.n));
            if (active) begin
                newb[j]        = !old_row[4*j + int'(sel)];
                wrow[4*j +: 4] = old_row[4*j +: 4] | (4'b0001 << sel);
            end
        end
    end

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            gsum[g] = '0;
            for (int k = 0; k < 8; k++) begin
                gsum[g] = gsum[g] + {3'b000, r_new[8*g + k]};
            end
        end
        tsum = '0;
        for (int g = 0; g < NG; g++) begin
            tsum = tsum + {3'b000, r_grp[g]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rowv  <= '0;
            r_total <= '0;
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_ov    <= 1'b0;
            r_row   <= '0;
        end else begin
            r_s1_v <= issue;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            if (r_s1_v) begin
                r_rowv[r_s1_row] <= 1'b1;
            end
            if (r_s3_v) begin
                r_total <= r_total + CW'(tsum);
            end
            if (issue) begin
                r_row <= r_row + 7'd1;
            end
            if (r_ov && o_result.ready && !(r_state == ST_FIN)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (take) begin
                        unique case (i_cmd.kind)
                            pct_pkg::KIND_ADD: begin
                                r_row   <= '0;
                                r_state <= ST_ADD;
                            end
                            pct_pkg::KIND_QUERY: begin
                                r_state <= i_cmd.invalid ? ST_FIN : ST_QRD;
                            end
                            pct_pkg::KIND_CLEAR: begin
                                r_rowv  <= '0;
                                r_total <= '0;
                                r_state <= ST_FIN;
                            end
                            pct_pkg::KIND_RSVD: begin
                                r_state <= ST_FIN;
                            end
                        endcase
                    end
                end
                ST_ADD: begin
                    if (!issue && !r_s1_v && !r_s2_v && !r_s3_v) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_QRD: begin
                    r_state <= ST_QWT;
                end
                ST_QWT: begin
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_state <= ST_IDLE;
                    end else if (o_result.ready) begin
                        r_ov <= 1'b0;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
        if (take) begin
            r_cmd <= i_cmd;
            r_cov <= 1'b0;
            r_inv <= (i_cmd.kind == pct_pkg::KIND_QUERY) && i_cmd.invalid;
        end
        if (r_state == ST_QWT) begin
            r_cov <= r_rowv[r_cmd.lo[AW-1:0]] && rdata[{r_cmd.hi[AW-1:0], r_cmd.pidx}];
        end
        if (issue) begin
            r_s1_row <= r_row[AW-1:0];
        end
        if (r_s1_v) begin
            r_new <= newb;
        end
        if (r_s2_v) begin
            for (int g = 0; g < NG; g++) begin
                r_grp[g] <= gsum[g];
            end
        end
        if ((r_state == ST_FIN) && out_free) begin
            r_oc   <= r_total;
            r_ocov <= r_cov;
            r_oinv <= r_inv;
        end
    end

    assign o_result.valid         = r_ov;
    assign o_result.covered_count = r_oc;
    assign o_result.pair_covered  = r_ocov;
    assign o_result.pair_invalid  = r_oinv;

endmodule

// ===== hdl/pairwise_coverage_tracker.sv =====
// Top level of the pairwise interaction coverage tracker.
`timescale 1ns / 1ps

// Pairwise coverage tracker. Every item gives exactly one result item. An add
// item marks, for each pair of tracked features i<j, the value combination the
// assignment shows; a query reports whether a literal pair has been seen and
// flags zero, out-of-range or repeated variables as invalid; a clear empties
// the store and zeroes the count. The marks live in one RAM of MAX_FEATURES
// rows, one row per lower feature, four mark bits per upper feature, so an add
// takes one read-modify-write per row through the single RAM port pair for N
// tracked features (MAX_FEATURES at most) and folds each row's new marks into
// the count: the new mark bits are registered, summed per group of eight and
// then added to the total.
// Row valid bits stand in for clearing, so no sweep is needed after reset.
// The front end and a two-entry queue keep taking items while the back end
// works. num_features may only be written while the block is idle; values
// above MAX_FEATURES act as MAX_FEATURES, and existing marks stay counted.
module pairwise_coverage_tracker #(
    parameter int MAX_FEATURES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [6:0]  i_cfg_wdata,
    pct_item_if.sink    i_item,
    pct_result_if.source o_result
);

    logic [6:0]    r_num_feat;
    logic [6:0]    num_feat;
    logic          f_valid, f_ready, q_valid, q_ready;
    pct_pkg::t_cmd f_cmd, q_cmd;

    // configuration register, reset to all features
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_feat <= 7'd64;
        end else if (i_cfg_we) begin
            r_num_feat <= i_cfg_wdata;
        end
    end

    // oversized setting clamps to the built store size
    assign num_feat = (r_num_feat > 7'(MAX_FEATURES)) ? 7'(MAX_FEATURES) : r_num_feat;

    pct_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_num_feat  (num_feat),
        .o_cmd_valid (f_valid),
        .i_cmd_ready (f_ready),
        .o_cmd       (f_cmd)
    );

    pct_cmd_fifo #(.DEPTH(2)) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (f_valid),
        .o_wr_ready (f_ready),
        .i_wr_cmd   (f_cmd),
        .o_rd_valid (q_valid),
        .i_rd_ready (q_ready),
        .o_rd_cmd   (q_cmd)
    );

    pct_back #(.MAX_FEATURES(MAX_FEATURES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .o_cmd_ready (q_ready),
        .i_cmd       (q_cmd),
        .o_result    (o_result)
    );

endmodule
